[hw/rtl/block_request_validator_top_macros.svh]
// Assertion macros shared by the block request validator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BLOCK_REQUEST_VALIDATOR_TOP_MACROS_SVH
`define BLOCK_REQUEST_VALIDATOR_TOP_MACROS_SVH

// Same-cycle implication under reset.
`define BRV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define BRV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/brv_pkg.sv]
// Types and constants of the block request validator.
// Depends on nothing; used by every RTL module of the block.
package brv_pkg;

    localparam logic [7:0]  OP_RD           = 8'd1;
    localparam logic [7:0]  OP_WR           = 8'd2;
    localparam logic [7:0]  OP_CAP          = 8'd3;
    localparam logic [24:0] HDR_LEN         = 25'd16;
    localparam logic [24:0] CAP_REPLY_LEN   = 25'd24;
    localparam logic [4:0]  RING_LOG2_MIN   = 5'd4;
    localparam logic [4:0]  RING_LOG2_MAX   = 5'd24;
    localparam logic [4:0]  RING_LOG2_RESET = 5'd16;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Configuration register indexes.
    localparam logic CFG_RING_LOG2 = 1'b0;
    localparam logic CFG_CAPACITY  = 1'b1;

    typedef enum logic [1:0] {
        ACT_WAIT_HDR   = 2'd0,
        ACT_WAIT_FRAME = 2'd1,
        ACT_WAIT_ROOM  = 2'd2,
        ACT_ANSWERED   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_DEVICE  = 2'd2,
        ST_UNSUP   = 2'd3
    } t_status;

    // Classified request as it travels from front to back. An action of
    // ACT_ANSWERED here means the frame is present and only room is left to check.
    typedef struct packed {
        logic        arm;
        t_action     action;
        t_status     status;
        logic [7:0]  op;
        logic [15:0] tag;
        logic [31:0] lba;
        logic [31:0] count;
        logic [23:0] frame;
        logic [23:0] rd_reply;
        logic [24:0] room;
    } t_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

[hw/rtl/brv_front.sv]
// Front end: configuration registers, input transfer and header classification.
// Depends on brv_pkg.
module brv_front #(
    parameter int BLOCK_BYTES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [47:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_arm_fault,
    input  logic [7:0]        i_request_op,
    input  logic [7:0]        i_request_flags,
    input  logic [15:0]       i_request_tag,
    input  logic [31:0]       i_request_lba,
    input  logic [31:0]       i_request_count,
    input  logic [31:0]       i_request_reserved,
    input  logic [24:0]       i_avail_bytes,
    input  logic [24:0]       i_room_bytes,
    input  brv_pkg::t_q_flags i_q_flags,
    output logic              o_push,
    output brv_pkg::t_req     o_req
);

    localparam int BB_W   = $clog2(BLOCK_BYTES + 1);
    localparam int PROD_W = 32 + BB_W;
    localparam int LEN_W  = PROD_W + 1;

    logic [4:0]       r_ring_log2;
    logic [47:0]      r_capacity;
    logic [4:0]       ring_log2;
    logic [LEN_W-1:0] limit;
    logic [LEN_W-1:0] blk_len;
    logic [LEN_W-1:0] frame;
    logic [LEN_W-1:0] reply_need;
    logic [32:0]      range_end;
    logic             is_rd;
    logic             is_wr;
    logic             is_cap;
    logic             wr_big;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_log2 <= brv_pkg::RING_LOG2_RESET;
            r_capacity  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                brv_pkg::CFG_RING_LOG2: r_ring_log2 <= i_cfg_data[4:0];
                brv_pkg::CFG_CAPACITY:  r_capacity  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_ring_log2 < brv_pkg::RING_LOG2_MIN) begin
            ring_log2 = brv_pkg::RING_LOG2_MIN;
        end else if (r_ring_log2 > brv_pkg::RING_LOG2_MAX) begin
            ring_log2 = brv_pkg::RING_LOG2_MAX;
        end else begin
            ring_log2 = r_ring_log2;
        end
    end

    assign limit   = (LEN_W'(1) << ring_log2) - LEN_W'(1);
    assign blk_len = LEN_W'(brv_pkg::HDR_LEN)
                   + LEN_W'(PROD_W'(i_request_count) * PROD_W'(BLOCK_BYTES));

    assign is_rd  = (i_request_op == brv_pkg::OP_RD);
    assign is_wr  = (i_request_op == brv_pkg::OP_WR);
    assign is_cap = (i_request_op == brv_pkg::OP_CAP);
    assign wr_big = is_wr && (i_request_count != '0) && (blk_len > limit);

    // An oversized write frame falls back to the bare header.
    assign frame = (is_wr && (i_request_count != '0) && !wr_big)
                 ? blk_len : LEN_W'(brv_pkg::HDR_LEN);

    always_comb begin
        if (is_rd) begin
            reply_need = blk_len;
        end else if (is_cap) begin
            reply_need = LEN_W'(brv_pkg::CAP_REPLY_LEN);
        end else begin
            reply_need = LEN_W'(brv_pkg::HDR_LEN);
        end
    end

    assign range_end = {1'b0, i_request_lba} + {1'b0, i_request_count};

    always_comb begin
        o_req.arm      = i_arm_fault;
        o_req.op       = i_request_op;
        o_req.tag      = i_request_tag;
        o_req.lba      = i_request_lba;
        o_req.count    = i_request_count;
        o_req.frame    = frame[23:0];
        o_req.rd_reply = blk_len[23:0];
        o_req.room     = i_room_bytes;

        if (i_avail_bytes < brv_pkg::HDR_LEN) begin
            o_req.action = brv_pkg::ACT_WAIT_HDR;
        end else if (LEN_W'(i_avail_bytes) < frame) begin
            o_req.action = brv_pkg::ACT_WAIT_FRAME;
        end else begin
            o_req.action = brv_pkg::ACT_ANSWERED;
        end

        if (!(is_rd || is_wr || is_cap)) begin
            o_req.status = brv_pkg::ST_UNSUP;
        end else if ((i_request_flags != '0) || (i_request_reserved != '0)) begin
            o_req.status = brv_pkg::ST_INVALID;
        end else if (wr_big || (reply_need > limit)) begin
            o_req.status = brv_pkg::ST_INVALID;
        end else if (is_cap) begin
            o_req.status = ((i_request_lba != '0) || (i_request_count != '0))
                         ? brv_pkg::ST_INVALID : brv_pkg::ST_OK;
        end else if (i_request_count == '0) begin
            o_req.status = brv_pkg::ST_INVALID;
        end else if (48'(range_end) > r_capacity) begin
            o_req.status = brv_pkg::ST_INVALID;
        end else begin
            o_req.status = brv_pkg::ST_OK;
        end
    end

    assign o_in_ready = !i_q_flags.full;
    assign o_push     = i_in_valid && o_in_ready;

endmodule

[hw/rtl/brv_queue.sv]
// Two-entry queue of classified requests between front and back.
// Depends on brv_pkg and the assertion macro header.
`include "block_request_validator_top_macros.svh"

module brv_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  brv_pkg::t_req     i_req,
    input  logic              i_pop,
    output brv_pkg::t_req     o_req,
    output brv_pkg::t_q_flags o_flags
);

    brv_pkg::t_req                r_mem [brv_pkg::QDEPTH];
    logic [brv_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [brv_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [brv_pkg::QCNT_W-1:0]   r_count;
    logic [brv_pkg::QPTR_W-1:0]   n_wr_ptr;
    logic [brv_pkg::QPTR_W-1:0]   n_rd_ptr;
    logic [brv_pkg::QCNT_W-1:0]   n_count;

    localparam logic [brv_pkg::QPTR_W-1:0] PTR_LAST = brv_pkg::QPTR_W'(brv_pkg::QDEPTH - 1);
    localparam logic [brv_pkg::QCNT_W-1:0] CNT_FULL = brv_pkg::QCNT_W'(brv_pkg::QDEPTH);

    assign o_flags.full  = (r_count == CNT_FULL);
    assign o_flags.empty = (r_count == '0);
    assign o_req         = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    `BRV_ASSERT_NOW(a_q_no_overflow, i_clk, i_rst_n, i_push, !o_flags.full || i_pop, "queue push while full")
    `BRV_ASSERT_NEXT(a_q_fill, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "queue fill count did not advance")

endmodule

[hw/rtl/brv_back.sv]
// Back end: fault and served state, room check, and the output register.
// Depends on brv_pkg and the assertion macro header.
`include "block_request_validator_top_macros.svh"

module brv_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  brv_pkg::t_req     i_req,
    input  brv_pkg::t_q_flags i_q_flags,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_action,
    output logic [1:0]        o_resp_status,
    output logic [23:0]       o_consume_bytes,
    output logic [23:0]       o_reply_bytes,
    output logic [7:0]        o_resp_op,
    output logic [15:0]       o_resp_tag,
    output logic [31:0]       o_resp_lba,
    output logic [31:0]       o_resp_count,
    output logic [31:0]       o_served_total
);

    logic              r_fault;
    logic [31:0]       r_served;
    logic              r_out_valid;
    brv_pkg::t_action  r_action;
    brv_pkg::t_status  r_status;
    logic [23:0]       r_consume;
    logic [23:0]       r_reply;
    logic [7:0]        r_op;
    logic [15:0]       r_tag;
    logic [31:0]       r_lba;
    logic [31:0]       r_count;
    logic [31:0]       r_served_total;

    logic              n_fault;
    logic [31:0]       n_served;
    brv_pkg::t_action  action;
    brv_pkg::t_status  status;
    logic [23:0]       reply;
    logic              armed;
    logic              faulted;
    logic              answer;

    assign o_pop = !i_q_flags.empty && (!r_out_valid || i_out_ready);

    // Arming takes effect before this request is judged.
    assign armed   = r_fault || i_req.arm;
    assign faulted = (i_req.action == brv_pkg::ACT_ANSWERED)
                  && (i_req.status == brv_pkg::ST_OK) && armed
                  && ((i_req.op == brv_pkg::OP_RD) || (i_req.op == brv_pkg::OP_WR));
    assign status  = faulted ? brv_pkg::ST_DEVICE : i_req.status;

    always_comb begin
        if ((status == brv_pkg::ST_OK) && (i_req.op == brv_pkg::OP_RD)) begin
            reply = i_req.rd_reply;
        end else if ((status == brv_pkg::ST_OK) && (i_req.op == brv_pkg::OP_CAP)) begin
            reply = brv_pkg::CAP_REPLY_LEN[23:0];
        end else begin
            reply = brv_pkg::HDR_LEN[23:0];
        end
    end

    always_comb begin
        if (i_req.action != brv_pkg::ACT_ANSWERED) begin
            action = i_req.action;
        end else if ({1'b0, reply} > i_req.room) begin
            action = brv_pkg::ACT_WAIT_ROOM;
        end else begin
            action = brv_pkg::ACT_ANSWERED;
        end
    end

    assign answer   = (action == brv_pkg::ACT_ANSWERED);
    assign n_fault  = (answer && faulted) ? 1'b0 : armed;
    assign n_served = r_served + 32'(answer);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault     <= 1'b0;
            r_served    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_fault     <= n_fault;
                r_served    <= n_served;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Waiting results carry zeros in every response field.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_action       <= action;
            r_status       <= answer ? status : brv_pkg::ST_OK;
            r_consume      <= answer ? i_req.frame : '0;
            r_reply        <= answer ? reply : '0;
            r_op           <= answer ? i_req.op : '0;
            r_tag          <= answer ? i_req.tag : '0;
            r_lba          <= answer ? i_req.lba : '0;
            r_count        <= (answer && (status == brv_pkg::ST_OK)) ? i_req.count : '0;
            r_served_total <= n_served;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_action        = r_action;
    assign o_resp_status   = r_status;
    assign o_consume_bytes = r_consume;
    assign o_reply_bytes   = r_reply;
    assign o_resp_op       = r_op;
    assign o_resp_tag      = r_tag;
    assign o_resp_lba      = r_lba;
    assign o_resp_count    = r_count;
    assign o_served_total  = r_served_total;

    `BRV_ASSERT_NEXT(a_hold_served, i_clk, i_rst_n, r_out_valid && !i_out_ready, $stable(r_served), "served count moved while output stalled")
    `BRV_ASSERT_NEXT(a_served_step, i_clk, i_rst_n, o_pop, r_served == $past(r_served) + 32'($past(answer)), "served count does not track answers")
    `BRV_ASSERT_NOW(a_wait_zero, i_clk, i_rst_n, r_out_valid && (r_action != brv_pkg::ACT_ANSWERED), (r_status == brv_pkg::ST_OK) && (r_consume == '0) && (r_reply == '0) && (r_count == '0), "waiting result carries response data")

endmodule

[hw/rtl/block_request_validator_top.sv]
// Top level of the block request validator.
// Depends on brv_pkg, brv_front, brv_queue and brv_back.

// Takes one request per clock cycle while results are taken and gives one
// result for each, in order. The front classifies a header in the cycle of
// its transfer (one multiply by BLOCK_BYTES, the ring and capacity compares)
// and writes it into a two-entry queue; the back applies the fault and served
// state and the room check and loads the output register as it pops the queue
// head, which holds a request while the output stalls. One request per cycle
// is taken as long as results are taken. Write the configuration registers
// only while no request is in flight.
module block_request_validator_top #(
    parameter int BLOCK_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_arm_fault,
    input  logic [7:0]  i_request_op,
    input  logic [7:0]  i_request_flags,
    input  logic [15:0] i_request_tag,
    input  logic [31:0] i_request_lba,
    input  logic [31:0] i_request_count,
    input  logic [31:0] i_request_reserved,
    input  logic [24:0] i_avail_bytes,
    input  logic [24:0] i_room_bytes,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_action,
    output logic [1:0]  o_resp_status,
    output logic [23:0] o_consume_bytes,
    output logic [23:0] o_reply_bytes,
    output logic [7:0]  o_resp_op,
    output logic [15:0] o_resp_tag,
    output logic [31:0] o_resp_lba,
    output logic [31:0] o_resp_count,
    output logic [31:0] o_served_total
);

    brv_pkg::t_req     front_req;
    brv_pkg::t_req     head_req;
    brv_pkg::t_q_flags q_flags;
    logic              push;
    logic              pop;

    brv_front #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_arm_fault       (i_arm_fault),
        .i_request_op      (i_request_op),
        .i_request_flags   (i_request_flags),
        .i_request_tag     (i_request_tag),
        .i_request_lba     (i_request_lba),
        .i_request_count   (i_request_count),
        .i_request_reserved(i_request_reserved),
        .i_avail_bytes     (i_avail_bytes),
        .i_room_bytes      (i_room_bytes),
        .i_q_flags         (q_flags),
        .o_push            (push),
        .o_req             (front_req)
    );

    brv_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_req  (front_req),
        .i_pop  (pop),
        .o_req  (head_req),
        .o_flags(q_flags)
    );

    brv_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (head_req),
        .i_q_flags      (q_flags),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_action       (o_action),
        .o_resp_status  (o_resp_status),
        .o_consume_bytes(o_consume_bytes),
        .o_reply_bytes  (o_reply_bytes),
        .o_resp_op      (o_resp_op),
        .o_resp_tag     (o_resp_tag),
        .o_resp_lba     (o_resp_lba),
        .o_resp_count   (o_resp_count),
        .o_served_total (o_served_total)
    );

endmodule
